// ===== hw/rtl/srm_pkg.sv =====
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types, constants and the control store for the slewed random
// modulator sequencer.
// ----------------------------------------------------------------------------
package srm_pkg;

    // config port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_RATE_CFG,
        REG_DEPTH_CFG,
        REG_MODE,
        REG_SAMPLE_PERIOD
    } reg_idx_t;

    localparam logic [14:0] RATE_CFG_RST      = 15'd1024;
    localparam logic [15:0] DEPTH_CFG_RST     = 16'd16384;
    localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd89478;

    localparam logic MODE_NOISE = 1'b0;
    localparam logic MODE_WALK  = 1'b1;

    // arithmetic constants
    localparam int RATE_MAX   = 20480;  // 20 Hz in 1/1024 Hz
    localparam int DEPTH_MAX  = 32768;  // 1.0 in Q1.15
    localparam int WALK_GAIN  = 3277;   // 0.1 in Q0.15
    localparam int TGT_FRAC   = 15;     // target level fraction bits
    localparam int STEP_ROUND = 16384;  // half LSB of walk step
    localparam int STEP_W     = 13;     // walk step fits +-3277
    localparam int RATE_FRAC  = 42;     // 10 rate frac + 32 period frac
    localparam int SLEW_FRAC  = 36;
    localparam int SLEW_W     = 37;     // slew in [0, 1], Q1.36
    localparam int SLEW_LO_W  = 18;     // low partial product slice

    // ------------------------------------------------------------------------
    // Control store
    // ------------------------------------------------------------------------
    typedef enum logic [3:0] {
        ST_WAIT,
        ST_MUL_INC,
        ST_PHASE,
        ST_TARGET,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_LEVEL,
        ST_MUL_OUT,
        ST_OUT
    } step_t;

    typedef enum logic [2:0] {
        MS_RATE,
        MS_WALK,
        MS_LO,
        MS_HI,
        MS_DEPTH
    } mul_sel_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_NO_WRAP,
        JC_GOTO
    } jump_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     ld_prod;
        logic     ld_phase;
        logic     ld_target;
        logic     ld_diff;
        logic     ld_acc;
        logic     ld_level;
        logic     ld_out;
        hold_t    hold;
        jump_t    jc;
        step_t    dest;
    } ucode_t;

    localparam ucode_t UC_NOP = '{
        mul_sel:   MS_RATE,
        ld_prod:   1'b0,
        ld_phase:  1'b0,
        ld_target: 1'b0,
        ld_diff:   1'b0,
        ld_acc:    1'b0,
        ld_level:  1'b0,
        ld_out:    1'b0,
        hold:      HOLD_NONE,
        jc:        JC_NEXT,
        dest:      ST_WAIT
    };

    function automatic ucode_t ucode_fetch(input step_t step);
        ucode_t uc;
        uc = UC_NOP;
        case (step)
            ST_WAIT:
            begin
                uc.hold = HOLD_IN;
            end
            ST_MUL_INC:
            begin
                uc.mul_sel = MS_RATE;
                uc.ld_prod = 1'b1;
            end
            ST_PHASE:
            begin
                uc.ld_phase = 1'b1;
                uc.mul_sel  = MS_WALK;
                uc.ld_prod  = 1'b1;
                uc.jc       = JC_NO_WRAP;
                uc.dest     = ST_DIFF;
            end
            ST_TARGET:
            begin
                uc.ld_target = 1'b1;
            end
            ST_DIFF:
            begin
                uc.ld_diff = 1'b1;
            end
            ST_MUL_LO:
            begin
                uc.mul_sel = MS_LO;
                uc.ld_prod = 1'b1;
            end
            ST_MUL_HI:
            begin
                uc.ld_acc  = 1'b1;
                uc.mul_sel = MS_HI;
                uc.ld_prod = 1'b1;
            end
            ST_LEVEL:
            begin
                uc.ld_level = 1'b1;
            end
            ST_MUL_OUT:
            begin
                uc.mul_sel = MS_DEPTH;
                uc.ld_prod = 1'b1;
            end
            ST_OUT:
            begin
                uc.ld_out = 1'b1;
                uc.hold   = HOLD_OUT;
                uc.jc     = JC_GOTO;
                uc.dest   = ST_WAIT;
            end
            default:
            begin
                uc.jc   = JC_GOTO;
                uc.dest = ST_WAIT;
            end
        endcase
        return uc;
    endfunction

endpackage

// ===== hw/rtl/slewed_random_modulator.sv =====
// ----------------------------------------------------------------------------
// slewed_random_modulator
// Smoothed random LFO: a phase accumulator draws a new noise or random-walk
// target on each wrap, the level glides toward it, output is depth * level.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | word
//  --------+----------------------------+-----------------------------------------
//  in      | in_valid, in_ready         | rate_mod, depth_mod, random_value
//  out     | out_valid, out_ready       | value
//  cfg     | psel, penable, pwrite      | paddr, pwdata, prdata, pready (4 regs)
//
//  One word is handled at a time by a 10-step microprogram around one shared
//  signed multiplier; the target step is skipped when the phase does not wrap.
//  The multiplier is used five times per word.
//  A new word is taken in the cycle after the result is loaded into the output
//  register, so a waiting result does not block the next input.
//  A result that cannot be loaded (output still full, not taken) holds the
//  sequencer in its last step. No clearing pass after reset.
//
module slewed_random_modulator #(
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [15:0]          rate_mod,
    input  logic signed [15:0]          depth_mod,
    input  logic        [15:0]          random_value,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [15:0]          value,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srm_pkg::ADDR_W-1:0]  paddr,
    input  logic [srm_pkg::DATA_W-1:0]  pwdata,
    output logic [srm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    import srm_pkg::*;

    // ------------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------------
    localparam int LW    = SAMPLE_BITS + 1;          // level, signed
    localparam int DW    = SAMPLE_BITS + 2;          // level difference
    localparam int AW    = (DW > 17) ? DW : 17;      // multiplier A, signed
    localparam int BW    = DATA_W + 1;               // multiplier B, positive
    localparam int MW    = AW + BW;                  // product
    localparam int IW    = PHASE_BITS + 5;           // phase increment
    localparam int SHIFT = RATE_FRAC - PHASE_BITS;   // product to phase units
    localparam int ACW   = DW + SLEW_W + 1;          // glide accumulator

    localparam logic [SLEW_W-1:0] SLEW_ONE   = {1'b1, {SLEW_FRAC{1'b0}}};
    localparam logic [ACW-1:0]    SLEW_ROUND =
        {{(ACW - SLEW_FRAC){1'b0}}, 1'b1, {(SLEW_FRAC - 1){1'b0}}};

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    // config
    logic [14:0]              rate_cfg_reg,      rate_cfg_next;
    logic [15:0]              depth_cfg_reg,     depth_cfg_next;
    logic                     mode_reg,          mode_next;
    logic [31:0]              sample_period_reg, sample_period_next;

    // sequencer and state
    step_t                    step_reg,          step_next;
    logic                     out_valid_reg,     out_valid_next;
    logic [PHASE_BITS-1:0]    phase_reg,         phase_next;
    logic signed [LW-1:0]     level_reg,         level_next;
    logic signed [15:0]       target_reg,        target_next;

    // per-word datapath
    logic [14:0]              rate_reg,          rate_next;
    logic [15:0]              depth_reg,         depth_next;
    logic [15:0]              rnd_reg,           rnd_next;
    logic signed [MW-1:0]     prod_reg,          prod_next;
    logic [SLEW_W-1:0]        slew_reg,          slew_next;
    logic signed [DW-1:0]     diff_reg,          diff_next;
    logic signed [ACW-1:0]    acc_reg,           acc_next;
    logic signed [15:0]       value_reg,         value_next;

    // ------------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------------
    ucode_t                   uc;
    logic                     in_accept;
    logic                     out_free;
    logic                     advance;
    logic                     cfg_write;
    reg_idx_t                 reg_sel;

    logic signed [19:0]       br8;
    logic signed [19:0]       rmod20;
    logic signed [19:0]       r8;
    logic signed [19:0]       r8_div;
    logic [14:0]              rate_calc;
    logic signed [17:0]       dsum;
    logic [15:0]              depth_calc;

    logic signed [AW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;
    logic signed [MW-1:0]     product;

    logic [IW-1:0]            inc;
    logic [IW:0]              phase_sum;
    logic                     wrap;
    logic                     slew_full;
    logic [SLEW_FRAC-1:0]     slew_frac;

    logic signed [15:0]       centered;
    logic signed [MW-1:0]     walk_step_sum;
    logic signed [STEP_W-1:0] walk_step;
    logic signed [15:0]       cur15;
    logic signed [16:0]       walk_sum;
    logic signed [15:0]       walk_target;

    logic signed [LW-1:0]     tgt_frac;
    logic signed [ACW-1:0]    glide_total;
    logic signed [DW-1:0]     delta;
    logic signed [MW-1:0]     out_wide;

    assign uc        = ucode_fetch(step_reg);
    assign in_ready  = (uc.hold == HOLD_IN);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = reg_idx_t'(paddr[3:2]);

    // register readback
    always_comb
    begin
        case (reg_sel)
            REG_RATE_CFG:      prdata = DATA_W'(rate_cfg_reg);
            REG_DEPTH_CFG:     prdata = DATA_W'(depth_cfg_reg);
            REG_MODE:          prdata = DATA_W'(mode_reg);
            REG_SAMPLE_PERIOD: prdata = sample_period_reg;
            default:           prdata = '0;
        endcase
    end

    // rate = floor((8*rate_cfg + 5*rate_mod) / 8), clamped to [1, 20480]
    always_comb
    begin
        br8    = signed'(20'({rate_cfg_reg, 3'b000}));
        rmod20 = 20'(rate_mod);
        r8     = br8 + (rmod20 <<< 2) + rmod20;
        r8_div = r8 >>> 3;
        if (r8 < 20'sd8)
            rate_calc = 15'd1;
        else if (r8_div > 20'(RATE_MAX))
            rate_calc = 15'(RATE_MAX);
        else
            rate_calc = r8_div[14:0];

        dsum = signed'(18'(depth_cfg_reg)) + 18'(depth_mod);
        if (dsum < 18'sd0)
            depth_calc = '0;
        else if (dsum > 18'(DEPTH_MAX))
            depth_calc = 16'(DEPTH_MAX);
        else
            depth_calc = dsum[15:0];
    end

    // shared multiplier
    always_comb
    begin
        case (uc.mul_sel)
            MS_RATE:
            begin
                mul_a = AW'({1'b0, rate_reg});
                mul_b = BW'(sample_period_reg);
            end
            MS_WALK:
            begin
                mul_a = AW'(centered);
                mul_b = BW'(WALK_GAIN);
            end
            MS_LO:
            begin
                mul_a = AW'(diff_reg);
                mul_b = BW'(slew_reg[SLEW_LO_W-1:0]);
            end
            MS_HI:
            begin
                mul_a = AW'(diff_reg);
                mul_b = BW'(slew_reg[SLEW_W-1:SLEW_LO_W]);
            end
            MS_DEPTH:
            begin
                mul_a = AW'(level_reg);
                mul_b = BW'(depth_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = mul_a * mul_b;
    end

    // phase step
    assign inc       = prod_reg[SHIFT +: IW];
    assign phase_sum = (IW + 1)'(phase_reg) + (IW + 1)'(inc);
    assign wrap      = |phase_sum[IW:PHASE_BITS];
    assign slew_full = |inc[IW-1:PHASE_BITS];

    // slew held as Q0.36
    if (PHASE_BITS >= SLEW_FRAC)
    begin : g_slew_trunc
        assign slew_frac = inc[PHASE_BITS-1 -: SLEW_FRAC];
    end
    else
    begin : g_slew_ext
        assign slew_frac = {inc[PHASE_BITS-1:0], {(SLEW_FRAC - PHASE_BITS){1'b0}}};
    end

    // Q1.15 <-> level format, floor shifts
    if (SAMPLE_BITS >= TGT_FRAC)
    begin : g_lvl_wide
        assign cur15    = level_reg[LW-1 -: 16];
        assign tgt_frac = LW'(target_reg) <<< (SAMPLE_BITS - TGT_FRAC);
    end
    else
    begin : g_lvl_narrow
        assign cur15    = 16'(level_reg) <<< (TGT_FRAC - SAMPLE_BITS);
        assign tgt_frac = target_reg[15 -: LW];
    end

    // new target: noise = r - 0.5 scaled, walk = level + 0.1 * noise
    assign centered      = signed'({~rnd_reg[15], rnd_reg[14:0]});
    assign walk_step_sum = prod_reg + MW'(STEP_ROUND);
    assign walk_step     = STEP_W'(walk_step_sum >>> TGT_FRAC);
    assign walk_sum      = 17'(cur15) + 17'(walk_step);

    always_comb
    begin
        if (walk_sum > 17'sd32767)
            walk_target = 16'sh7FFF;
        else if (walk_sum < -17'sd32768)
            walk_target = 16'sh8000;
        else
            walk_target = walk_sum[15:0];
    end

    // glide: diff * slew built from two partial products, rounded
    assign glide_total = acc_reg + (ACW'(prod_reg) <<< SLEW_LO_W);
    assign delta       = DW'(glide_total >>> SLEW_FRAC);
    assign out_wide    = prod_reg >>> SAMPLE_BITS;

    // ------------------------------------------------------------------------
    // Sequencer and next-state logic
    // ------------------------------------------------------------------------
    always_comb
    begin
        rate_cfg_next      = rate_cfg_reg;
        depth_cfg_next     = depth_cfg_reg;
        mode_next          = mode_reg;
        sample_period_next = sample_period_reg;
        step_next          = step_reg;
        out_valid_next     = out_valid_reg;
        phase_next         = phase_reg;
        level_next         = level_reg;
        target_next        = target_reg;
        rate_next          = rate_reg;
        depth_next         = depth_reg;
        rnd_next           = rnd_reg;
        prod_next          = prod_reg;
        slew_next          = slew_reg;
        diff_next          = diff_reg;
        acc_next           = acc_reg;
        value_next         = value_reg;

        if (cfg_write)
        begin
            case (reg_sel)
                REG_RATE_CFG:      rate_cfg_next      = pwdata[14:0];
                REG_DEPTH_CFG:     depth_cfg_next     = pwdata[15:0];
                REG_MODE:          mode_next          = pwdata[0];
                REG_SAMPLE_PERIOD: sample_period_next = pwdata;
                default:           ;
            endcase
        end

        case (uc.hold)
            HOLD_IN:  advance = in_valid;
            HOLD_OUT: advance = out_free;
            default:  advance = 1'b1;
        endcase

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (in_accept)
        begin
            rate_next  = rate_calc;
            depth_next = depth_calc;
            rnd_next   = random_value;
        end

        if (advance)
        begin
            if (uc.ld_prod)
                prod_next = product;
            if (uc.ld_phase)
            begin
                phase_next = phase_sum[PHASE_BITS-1:0];
                slew_next  = slew_full ? SLEW_ONE : {1'b0, slew_frac};
            end
            if (uc.ld_target)
                target_next = (mode_reg == MODE_NOISE) ? centered : walk_target;
            if (uc.ld_diff)
                diff_next = DW'(tgt_frac) - DW'(level_reg);
            if (uc.ld_acc)
                acc_next = ACW'(prod_reg) + signed'(SLEW_ROUND);
            if (uc.ld_level)
                level_next = level_reg + LW'(delta);
            if (uc.ld_out)
            begin
                out_valid_next = 1'b1;
                if (out_wide > MW'(32767))
                    value_next = 16'sh7FFF;
                else if (out_wide < MW'(-32768))
                    value_next = 16'sh8000;
                else
                    value_next = out_wide[15:0];
            end

            case (uc.jc)
                JC_NEXT:    step_next = step_t'(step_reg + 4'd1);
                JC_NO_WRAP: step_next = wrap ? step_t'(step_reg + 4'd1) : uc.dest;
                JC_GOTO:    step_next = uc.dest;
                default:    step_next = ST_WAIT;
            endcase
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_cfg_reg      <= RATE_CFG_RST;
            depth_cfg_reg     <= DEPTH_CFG_RST;
            mode_reg          <= MODE_WALK;
            sample_period_reg <= SAMPLE_PERIOD_RST;
            step_reg          <= ST_WAIT;
            out_valid_reg     <= 1'b0;
            phase_reg         <= '0;
            level_reg         <= '0;
            target_reg        <= '0;
        end
        else
        begin
            rate_cfg_reg      <= rate_cfg_next;
            depth_cfg_reg     <= depth_cfg_next;
            mode_reg          <= mode_next;
            sample_period_reg <= sample_period_next;
            step_reg          <= step_next;
            out_valid_reg     <= out_valid_next;
            phase_reg         <= phase_next;
            level_reg         <= level_next;
            target_reg        <= target_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        rate_reg  <= rate_next;
        depth_reg <= depth_next;
        rnd_reg   <= rnd_next;
        prod_reg  <= prod_next;
        slew_reg  <= slew_next;
        diff_reg  <= diff_next;
        acc_reg   <= acc_next;
        value_reg <= value_next;
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: slewed random modulator testbench
// Drives words with random gaps and stalls and predicts each output sample
// with a fixed-point model of the LFO. Compares every output word in order,
// and reads back each register after it is written.
// ----------------------------------------------------------------------------
module tb_top;

    import srm_pkg::*;

    // ------------------------------------------------------------------------
    // Limits
    // ------------------------------------------------------------------------
    // Worst case between two handshakes: a sender gap, the 10-step sequence and a
    // receiver stall, plus a register write with readback. Taken many times over.
    localparam int QUIET_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 12;     // one word through the sequencer
    localparam int RANDOM_SETS  = 10;     // register settings in random traffic
    localparam int WORDS_PER_SET = 73;

    // model constants, Q-formats as in the block
    localparam longint PHASE_ONE  = 64'sd1 <<< 32;
    localparam longint RATE_TOP   = 20480;
    localparam longint DEPTH_TOP  = 32768;
    localparam longint STEP_GAIN  = 3277;
    localparam longint LEVEL_LO   = -32768;
    localparam longint LEVEL_HI   = 32767;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [15:0]        rate_mod;
    logic signed [15:0]        depth_mod;
    logic        [15:0]        random_value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [15:0]        value;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    slewed_random_modulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rate_mod     (rate_mod),
        .depth_mod    (depth_mod),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------------
    // Model state: register copies and the LFO state
    // ------------------------------------------------------------------------
    logic [14:0] cfg_rate   = RATE_CFG_RST;
    logic [15:0] cfg_depth  = DEPTH_CFG_RST;
    logic        cfg_mode   = MODE_WALK;
    logic [31:0] cfg_period = SAMPLE_PERIOD_RST;

    longint lfo_phase  = 0;   // Q0.32
    longint lfo_level  = 0;   // Q.16
    longint lfo_target = 0;   // Q1.15

    logic signed [15:0] expected_values[$];
    logic signed [15:0] head_value;
    int                 mismatch_count = 0;
    int                 quiet_cycles   = 0;
    logic               no_gaps        = 1'b0;   // both sides run flat out

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point LFO model
    // ------------------------------------------------------------------------
    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // One sample: advance phase, maybe draw a target, glide, scale by depth.
    function automatic logic signed [15:0] predict_value(input logic signed [15:0] rm,
                                                         input logic signed [15:0] dm,
                                                         input logic [15:0] rv);
        longint r8;
        longint rate;
        longint depth;
        longint inc;
        longint sum;
        longint centered;
        longint step;
        longint slew36;
        longint tgt;
        longint delta;
        longint scaled;
        // rate control is +-20 Hz full scale: 20 * 1024 / 32768 = 5/8
        r8    = longint'(cfg_rate) * 8 + longint'(rm) * 5;
        rate  = (r8 < 8) ? 1 : clip(r8 >>> 3, 1, RATE_TOP);
        depth = clip(longint'(cfg_depth) + longint'(dm), 0, DEPTH_TOP);

        // rate has 10 fraction bits, period 32: drop 10 to land in Q0.32
        inc       = (rate * longint'(cfg_period)) >>> 10;
        sum       = lfo_phase + inc;
        lfo_phase = sum & (PHASE_ONE - 1);

        // at most one new target per sample, even for huge increments
        if (sum >= PHASE_ONE)
        begin
            centered = longint'(rv) - 32768;
            if (cfg_mode == MODE_NOISE)
                lfo_target = centered;
            else
            begin
                step       = (centered * STEP_GAIN + 16384) >>> 15;
                lfo_target = clip((lfo_level >>> 1) + step, LEVEL_LO, LEVEL_HI);
            end
        end

        // glide by min(inc, 1) in Q.36, rounded
        slew36    = ((inc > PHASE_ONE) ? PHASE_ONE : inc) <<< 4;
        tgt       = lfo_target <<< 1;
        delta     = ((tgt - lfo_level) * slew36 + (64'sd1 <<< 35)) >>> 36;
        lfo_level = lfo_level + delta;

        scaled = clip((depth * lfo_level) >>> 16, LEVEL_LO, LEVEL_HI);
        return 16'(scaled);
    endfunction

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predict on input handshake, check on output handshake
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (out_valid && out_ready)
            begin
                quiet_cycles = 0;
                if (expected_values.size() == 0)
                    flag_mismatch("output word with none pending", 64'sd0, longint'(value));
                else
                begin
                    head_value = expected_values.pop_front();
                    if (value !== head_value)
                        flag_mismatch("value", longint'(head_value), longint'(value));
                end
            end
            if (in_valid && in_ready)
            begin
                quiet_cycles = 0;
                expected_values.push_back(predict_value(rate_mod, depth_mod, random_value));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any handshake
    // ------------------------------------------------------------------------
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("FAIL slewed_random_modulator");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: random stall before each word, none in flat-out stretches
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Valid stays high across back-to-back words; send_word drops it only for a gap.
    task automatic send_word(input logic signed [15:0] rm, input logic signed [15:0] dm,
                             input logic [15:0] rv);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        rate_mod     <= rm;
        depth_mod    <= dm;
        random_value <= rv;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_word();
        send_word(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Sender holds off until every pending output word has come back.
    task automatic settle_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
    endtask

    // APB write then read back; only called with the block idle.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        logic [31:0] kept;
        case (idx)
            REG_RATE_CFG:
            begin
                cfg_rate = data[14:0];
                kept     = {17'd0, data[14:0]};
            end
            REG_DEPTH_CFG:
            begin
                cfg_depth = data[15:0];
                kept      = {16'd0, data[15:0]};
            end
            REG_MODE:
            begin
                cfg_mode = data[0];
                kept     = {31'd0, data[0]};
            end
            default:
            begin
                cfg_period = data;
                kept       = data;
            end
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== kept)
            flag_mismatch("register readback", longint'(kept), longint'(prdata));
        quiet_cycles = 0;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] rate, input logic [31:0] depth,
                            input logic mode, input logic [31:0] period);
        write_reg(REG_RATE_CFG, rate);
        write_reg(REG_DEPTH_CFG, depth);
        write_reg(REG_MODE, {31'd0, mode});
        write_reg(REG_SAMPLE_PERIOD, period);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset settings: 1 Hz walk at 48 kHz, nothing wraps yet.
    task automatic test_reset_state();
        send_word(16'sd0, 16'sd0, 16'h1234);
        send_word(16'sh7FFF, 16'sd0, 16'hFFFF);
        settle_results();
    endtask

    // Field extremes with noise targets; with the huge period every sample above
    // the rate floor wraps with an increment above one and draws a fresh target.
    task automatic test_field_extremes();
        set_regs(32'(RATE_TOP), 32'(DEPTH_TOP), MODE_NOISE, 32'hFFFF_FFFF);
        send_word(-16'sd32768, -16'sd32768, 16'h0000);
        send_word(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
        send_word(16'sd0, 16'sd0, 16'h8000);
        send_word(16'sh7FFF, -16'sd32768, 16'h0001);
        send_word(-16'sd32768, 16'sh7FFF, 16'h7FFF);
        settle_results();
    endtask

    // Walk targets at an increment of about 0.4: steps up then down.
    task automatic test_walk_targets();
        set_regs(32'(RATE_TOP), 32'(DEPTH_TOP), MODE_WALK, 32'd85899346);
        repeat (3) send_word(16'sd0, 16'sd0, 16'hFFFF);
        repeat (2) send_word(16'sd0, 16'sd0, 16'h0000);
        settle_results();
    endtask

    // Zero sample period: phase frozen, level holds.
    task automatic test_zero_period();
        write_reg(REG_SAMPLE_PERIOD, 32'd0);
        repeat (3) send_random_word();
        settle_results();
    endtask

    // Increment below one LSB for the first two words: slew truncates to zero. The
    // rate floor is hit with the most negative rate control.
    task automatic test_tiny_slew();
        set_regs(32'd1, 32'd20000, MODE_NOISE, 32'd500);
        send_word(16'sd0, 16'sd0, 16'hA5A5);
        send_word(-16'sd32768, 16'sd0, 16'h5A5A);
        send_word(16'sd100, -16'sd1, 16'h0F0F);
        settle_results();
    endtask

    // Depth register over 1.0 and under 0 after the control; base rate at
    // zero and at the register maximum.
    task automatic test_depth_limits();
        set_regs(32'd0, 32'd65535, MODE_WALK, SAMPLE_PERIOD_RST);
        send_word(16'sd0, 16'sd0, 16'h1111);
        send_word(16'sd0, -16'sd32768, 16'h2222);
        settle_results();
        write_reg(REG_RATE_CFG, 32'd32767);
        write_reg(REG_DEPTH_CFG, 32'd0);
        send_word(16'sd0, -16'sd1, 16'h3333);
        send_word(16'sd0, 16'sh7FFF, 16'h4444);
        settle_results();
    endtask

    // Random words over several random settings. Periods are biased toward
    // large values so the phase wraps often and walks reach the rails.
    task automatic test_random_traffic();
        logic [31:0] rate;
        logic [31:0] depth;
        logic [31:0] period;
        for (int set_no = 0; set_no < RANDOM_SETS; set_no++)
        begin
            case ($urandom_range(0, 5))
                0: rate = 32'd0;
                1: rate = 32'd1;
                2: rate = 32'(RATE_TOP);
                3: rate = 32'd32767;
                default: rate = $urandom_range(1, 32'(RATE_TOP));
            endcase
            case ($urandom_range(0, 4))
                0: depth = 32'd0;
                1: depth = 32'(DEPTH_TOP);
                2: depth = 32'd65535;
                default: depth = $urandom_range(0, 32'(DEPTH_TOP));
            endcase
            case ($urandom_range(0, 6))
                0: period = 32'd0;
                1: period = 32'd1;
                2: period = 32'hFFFF_FFFF;
                default: period = $urandom >> $urandom_range(0, 10);
            endcase
            set_regs(rate, depth, 1'($urandom_range(0, 1)), period);
            no_gaps = (set_no % 4 == 1);
            for (int n = 0; n < WORDS_PER_SET; n++)
            begin
                // one hold-off in the middle of traffic
                if (set_no == 5 && n == WORDS_PER_SET / 2)
                    settle_results();
                send_random_word();
            end
            settle_results();
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rate_mod     = '0;
        depth_mod    = '0;
        random_value = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_field_extremes();
        test_walk_targets();
        test_zero_period();
        test_tiny_slew();
        test_depth_limits();
        test_random_traffic();

        settle_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_values.size() == 0)
            $display("PASS slewed_random_modulator");
        else
            $display("FAIL slewed_random_modulator");
        $finish;
    end

endmodule
